// File: sv/cmr_pkg.sv
// ----------------------------------------------------------------------------
// cmr_pkg
// Shared types and constants for the confirmable message retransmitter
// ----------------------------------------------------------------------------
package cmr_pkg;

  localparam int TIMER_WIDTH_DEF = 32;
  localparam int ID_W            = 16;
  localparam int BASE_W          = 16;
  localparam int RETX_W          = 4;
  localparam int RETRY_W         = 5;
  localparam int JIT_W           = 8;
  localparam int JIT_SHIFT       = 9;
  localparam int RTT_W           = 32;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 16;

  // action codes
  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_TICK  = 2'd1;
  localparam logic [1:0] ACT_ACK   = 2'd2;
  localparam logic [1:0] ACT_OTHER = 2'd3;

  // outcome codes
  localparam logic [2:0] OUT_NONE     = 3'd0;
  localparam logic [2:0] OUT_FIRST    = 3'd1;
  localparam logic [2:0] OUT_RETX     = 3'd2;
  localparam logic [2:0] OUT_GAVE_UP  = 3'd3;
  localparam logic [2:0] OUT_ACK_OK   = 3'd4;
  localparam logic [2:0] OUT_ACK_MISS = 3'd5;
  localparam logic [2:0] OUT_ERROR    = 3'd6;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ACK_TIMEOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RETX    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_ID    = 2'd2;

  localparam logic [BASE_W-1:0] ACK_TIMEOUT_RST = 16'd2000;
  localparam logic [RETX_W-1:0] MAX_RETX_RST    = 4'd4;
  localparam logic [ID_W-1:0]   FIRST_ID_RST    = 16'd0;

  typedef struct packed {
    logic [1:0]       action;
    logic [ID_W-1:0]  ack_id;
    logic [JIT_W-1:0] jitter;
  } item_t;

  typedef struct packed {
    logic             send_valid;
    logic [ID_W-1:0]  message_id;
    logic [2:0]       outcome;
    logic [RTT_W-1:0] round_trip_ticks;
  } result_t;

  typedef struct packed {
    logic [BASE_W-1:0] ack_timeout_ticks;
    logic [RETX_W-1:0] retx_limit;
    logic [ID_W-1:0]   first_message_id;
  } cfg_t;

endpackage

// File: sv/confirmable_message_retransmitter_top.sv
// An accepted input transfer passes the input register and then the result register to the output.
// Throughput: one item per cycle unless the output stalls; the input register feeds the
// state update and the output register holds the result, so a new item moves every cycle.
// A stalled output holds its result while one more item waits in the input register.
// Reset (rst, synchronous) empties both registers, clears the state to idle and
// loads the register defaults; the block takes items on the next cycle.
// ----------------------------------------------------------------------------
// confirmable_message_retransmitter_top
// Sender side of confirmable messaging with exponential backoff
// ----------------------------------------------------------------------------
module confirmable_message_retransmitter_top #(
  parameter int TIMER_WIDTH = cmr_pkg::TIMER_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  cmr_pkg::item_t                  in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output cmr_pkg::result_t                out_data,
  input  logic                            cfg_write,
  input  logic [cmr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cmr_pkg::CFG_DATA_W-1:0]  cfg_data
);

  cmr_pkg::cfg_t    cfg;
  cmr_pkg::item_t   item;
  cmr_pkg::result_t result;
  logic             item_valid;
  logic             advance;
  logic             go;

  assign advance  = !out_valid || !out_stall;
  assign go       = item_valid && advance;
  assign in_stall = item_valid && !advance;

  cmr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  cmr_core #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .go     (go),
    .item   (item),
    .cfg    (cfg),
    .result (result)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item <= in_data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_data <= result;
    end
  end

endmodule

// File: sv/cmr_cfg.sv
// ----------------------------------------------------------------------------
// cmr_cfg
// Configuration register file, write only
// ----------------------------------------------------------------------------
module cmr_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [cmr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cmr_pkg::CFG_DATA_W-1:0]   cfg_data,
  output cmr_pkg::cfg_t                    cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ack_timeout_ticks <= cmr_pkg::ACK_TIMEOUT_RST;
      cfg.retx_limit        <= cmr_pkg::MAX_RETX_RST;
      cfg.first_message_id  <= cmr_pkg::FIRST_ID_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        cmr_pkg::REG_ACK_TIMEOUT: cfg.ack_timeout_ticks <= cfg_data[cmr_pkg::BASE_W-1:0];
        cmr_pkg::REG_MAX_RETX:    cfg.retx_limit        <= cfg_data[cmr_pkg::RETX_W-1:0];
        cmr_pkg::REG_FIRST_ID:    cfg.first_message_id  <= cfg_data[cmr_pkg::ID_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// File: sv/cmr_core.sv
// ----------------------------------------------------------------------------
// cmr_core
// Retransmission state and the single-pass update for one item
// ----------------------------------------------------------------------------
module cmr_core #(
  parameter int TIMER_WIDTH = cmr_pkg::TIMER_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               go,
  input  cmr_pkg::item_t     item,
  input  cmr_pkg::cfg_t      cfg,
  output cmr_pkg::result_t   result
);

  localparam int TW = TIMER_WIDTH;
  localparam int PROD_W = cmr_pkg::BASE_W + cmr_pkg::JIT_W;

  logic [cmr_pkg::ID_W-1:0]    current_id, current_id_next;
  logic [cmr_pkg::RETRY_W-1:0] retry_count, retry_count_next;
  logic [TW-1:0]               timeout_length, timeout_length_next;
  logic [TW-1:0]               ticks_remaining, ticks_remaining_next;
  logic [TW-1:0]               ticks_since, ticks_since_next;
  logic                        running, running_next;

  logic [PROD_W-1:0]           jit_prod;
  logic [TW-1:0]               fresh;
  logic [TW-1:0]               doubled;
  logic [TW-1:0]               ticks_inc;
  logic [cmr_pkg::RETRY_W-1:0] retry_inc;
  logic [cmr_pkg::RTT_W-1:0]   rtt_sat;
  logic [cmr_pkg::ID_W-1:0]    id_inc;

  // base plus base*jitter/512, never wider than 17 bits so no saturation
  assign jit_prod = PROD_W'(cfg.ack_timeout_ticks) * PROD_W'(item.jitter);
  assign fresh    = TW'(cfg.ack_timeout_ticks) + TW'(jit_prod >> cmr_pkg::JIT_SHIFT);
  assign doubled  = timeout_length[TW-1] ? {TW{1'b1}} : {timeout_length[TW-2:0], 1'b0};
  assign ticks_inc = (&ticks_since) ? ticks_since : ticks_since + TW'(1);
  assign retry_inc = retry_count + cmr_pkg::RETRY_W'(1);
  assign id_inc    = current_id + cmr_pkg::ID_W'(1);

  generate
    if (TW > cmr_pkg::RTT_W) begin : g_rtt_sat
      assign rtt_sat = (|ticks_since[TW-1:cmr_pkg::RTT_W]) ? {cmr_pkg::RTT_W{1'b1}}
                                                           : ticks_since[cmr_pkg::RTT_W-1:0];
    end else begin : g_rtt_ext
      assign rtt_sat = cmr_pkg::RTT_W'(ticks_since);
    end
  endgenerate

  always_comb begin
    current_id_next      = current_id;
    retry_count_next     = retry_count;
    timeout_length_next  = timeout_length;
    ticks_remaining_next = ticks_remaining;
    ticks_since_next     = ticks_since;
    running_next         = running;
    result.send_valid       = 1'b0;
    result.outcome          = cmr_pkg::OUT_NONE;
    result.round_trip_ticks = '0;

    case (item.action)
      cmr_pkg::ACT_START: begin
        current_id_next      = cfg.first_message_id;
        retry_count_next     = '0;
        timeout_length_next  = fresh;
        ticks_remaining_next = fresh;
        ticks_since_next     = '0;
        running_next         = 1'b1;
        result.send_valid    = 1'b1;
        result.outcome       = cmr_pkg::OUT_FIRST;
      end
      cmr_pkg::ACT_TICK: begin
        if (running) begin
          ticks_since_next = ticks_inc;
          // expiry when one or zero ticks were left
          if (ticks_remaining <= TW'(1)) begin
            result.send_valid = 1'b1;
            if (retry_inc <= cmr_pkg::RETRY_W'(cfg.retx_limit)) begin
              retry_count_next     = retry_inc;
              timeout_length_next  = doubled;
              ticks_remaining_next = doubled;
              result.outcome       = cmr_pkg::OUT_RETX;
            end else begin
              current_id_next      = id_inc;
              retry_count_next     = '0;
              timeout_length_next  = fresh;
              ticks_remaining_next = fresh;
              ticks_since_next     = '0;
              result.outcome       = cmr_pkg::OUT_GAVE_UP;
            end
          end else begin
            ticks_remaining_next = ticks_remaining - TW'(1);
          end
        end
      end
      cmr_pkg::ACT_ACK: begin
        if (running) begin
          result.send_valid = 1'b1;
          if (item.ack_id == current_id) begin
            result.round_trip_ticks = rtt_sat;
            current_id_next      = id_inc;
            retry_count_next     = '0;
            timeout_length_next  = fresh;
            ticks_remaining_next = fresh;
            ticks_since_next     = '0;
            result.outcome       = cmr_pkg::OUT_ACK_OK;
          end else begin
            timeout_length_next  = doubled;
            ticks_remaining_next = doubled;
            result.outcome       = cmr_pkg::OUT_ACK_MISS;
          end
        end
      end
      default: begin
        result.outcome = cmr_pkg::OUT_ERROR;
      end
    endcase

    result.message_id = current_id_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_id      <= '0;
      retry_count     <= '0;
      timeout_length  <= '0;
      ticks_remaining <= '0;
      ticks_since     <= '0;
      running         <= 1'b0;
    end else if (go) begin
      current_id      <= current_id_next;
      retry_count     <= retry_count_next;
      timeout_length  <= timeout_length_next;
      ticks_remaining <= ticks_remaining_next;
      ticks_since     <= ticks_since_next;
      running         <= running_next;
    end
  end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the confirmable message retransmitter against a cycle-free predictor
// of its backoff, retransmit and give-up behavior. A queue-fed driver offers
// directed and random items under random idling on both sides. A monitor
// compares every output transfer with the oldest predicted result.
// ----------------------------------------------------------------------------
module testbench;

  localparam int TW = cmr_pkg::TIMER_WIDTH_DEF;
  localparam logic [TW-1:0] TIMER_MAX = {TW{1'b1}};

  typedef struct {
    cmr_pkg::item_t it;
    bit             ack_cur;   // fill ack_id with the current message id when driven
  } stim_t;

  logic                           clk       = 1'b0;
  logic                           rst       = 1'b1;
  logic                           in_valid  = 1'b0;
  logic                           in_stall;
  cmr_pkg::item_t                 in_data   = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  cmr_pkg::result_t               out_data;
  logic                           cfg_write = 1'b0;
  logic [cmr_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [cmr_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  // predictor configuration and state
  logic [cmr_pkg::BASE_W-1:0]  cfg_base     = cmr_pkg::ACK_TIMEOUT_RST;
  logic [cmr_pkg::RETX_W-1:0]  cfg_max_retx = cmr_pkg::MAX_RETX_RST;
  logic [cmr_pkg::ID_W-1:0]    cfg_first_id = cmr_pkg::FIRST_ID_RST;
  logic [cmr_pkg::ID_W-1:0]    cur_id       = '0;
  logic [cmr_pkg::RETRY_W-1:0] retry_cnt    = '0;
  logic [TW-1:0]               tmo_len      = '0;
  logic [TW-1:0]               ticks_left   = '0;
  logic [TW-1:0]               since_first  = '0;
  logic                        running      = 1'b0;

  stim_t            stim_q[$];
  cmr_pkg::result_t result_q[$];
  int      err_count    = 0;
  bit      in_fired     = 1'b0;
  int      snd_idle_pct = 0;
  int      rcv_idle_pct = 0;
  bit      hold_req     = 1'b0;
  bit      hold_taken   = 1'b0;
  int      hold_left    = 0;

  confirmable_message_retransmitter_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  function automatic logic [TW-1:0] doubled_timeout(logic [TW-1:0] t);
    logic [TW:0] d;
    d = {t, 1'b0};
    return d[TW] ? TIMER_MAX : d[TW-1:0];
  endfunction

  // new message id with a fresh timeout of base * (1 + jitter / 512)
  function automatic void start_message(logic [cmr_pkg::ID_W-1:0] id,
                                        logic [cmr_pkg::JIT_W-1:0] jit);
    logic [TW-1:0] base;
    base        = TW'(cfg_base);
    cur_id      = id;
    retry_cnt   = '0;
    tmo_len     = base + ((base * TW'(jit)) >> cmr_pkg::JIT_SHIFT);
    ticks_left  = tmo_len;
    since_first = '0;
  endfunction

  function automatic cmr_pkg::result_t advance_sender(cmr_pkg::item_t it);
    cmr_pkg::result_t r;
    r = '0;
    case (it.action)
      cmr_pkg::ACT_START: begin
        start_message(cfg_first_id, it.jitter);
        running      = 1'b1;
        r.send_valid = 1'b1;
        r.outcome    = cmr_pkg::OUT_FIRST;
      end
      cmr_pkg::ACT_TICK: begin
        if (running) begin
          if (since_first != TIMER_MAX) since_first = since_first + 1'b1;
          if (ticks_left <= 1) begin
            retry_cnt    = retry_cnt + 1'b1;
            r.send_valid = 1'b1;
            if (retry_cnt <= cmr_pkg::RETRY_W'(cfg_max_retx)) begin
              tmo_len    = doubled_timeout(tmo_len);
              ticks_left = tmo_len;
              r.outcome  = cmr_pkg::OUT_RETX;
            end else begin
              start_message(cur_id + 1'b1, it.jitter);
              r.outcome = cmr_pkg::OUT_GAVE_UP;
            end
          end else begin
            ticks_left = ticks_left - 1'b1;
          end
        end
      end
      cmr_pkg::ACT_ACK: begin
        if (running) begin
          r.send_valid = 1'b1;
          if (it.ack_id == cur_id) begin
            r.round_trip_ticks = cmr_pkg::RTT_W'(since_first);
            start_message(cur_id + 1'b1, it.jitter);
            r.outcome = cmr_pkg::OUT_ACK_OK;
          end else begin
            tmo_len    = doubled_timeout(tmo_len);
            ticks_left = tmo_len;
            r.outcome  = cmr_pkg::OUT_ACK_MISS;
          end
        end
      end
      default: r.outcome = cmr_pkg::OUT_ERROR;
    endcase
    r.message_id = cur_id;
    return r;
  endfunction

  // driver: loads the next item once the previous one has made its transfer
  always @(negedge clk) begin
    stim_t s;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fired) begin
      if (stim_q.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
        s = stim_q.pop_front();
        if (s.ack_cur) s.it.ack_id = cur_id;
        in_data  <= s.it;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall, with one long hold-off so the block backs up
  always @(negedge clk) begin
    if (hold_req && !hold_taken) begin
      hold_left  = 400;
      hold_taken = 1'b1;
    end
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < rcv_idle_pct);
    end
  end

  // monitor: predict on input transfers, check on output transfers
  always @(posedge clk) begin
    cmr_pkg::result_t want;
    in_fired = 1'b0;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        result_q.push_back(advance_sender(in_data));
        in_fired = 1'b1;
      end
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          err_count++;
          if (err_count <= 10) $display("unexpected result transfer: %p", out_data);
        end else begin
          want = result_q.pop_front();
          if (out_data.send_valid !== want.send_valid ||
              out_data.message_id !== want.message_id ||
              out_data.outcome !== want.outcome ||
              out_data.round_trip_ticks !== want.round_trip_ticks) begin
            err_count++;
            if (err_count <= 10)
              $display("mismatch (exp/act): send %0b/%0b id %0h/%0h outcome %0d/%0d rtt %0d/%0d",
                       want.send_valid, out_data.send_valid,
                       want.message_id, out_data.message_id,
                       want.outcome, out_data.outcome,
                       want.round_trip_ticks, out_data.round_trip_ticks);
          end
        end
      end
    end
  end

  task automatic write_reg(logic [cmr_pkg::CFG_IDX_W-1:0] idx,
                           logic [cmr_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      cmr_pkg::REG_ACK_TIMEOUT: cfg_base     = val;
      cmr_pkg::REG_MAX_RETX:    cfg_max_retx = val[cmr_pkg::RETX_W-1:0];
      cmr_pkg::REG_FIRST_ID:    cfg_first_id = val;
      default: ;
    endcase
  endtask

  task automatic configure(logic [cmr_pkg::BASE_W-1:0] base,
                           logic [cmr_pkg::RETX_W-1:0] retx,
                           logic [cmr_pkg::ID_W-1:0] first);
    write_reg(cmr_pkg::REG_ACK_TIMEOUT, base);
    write_reg(cmr_pkg::REG_MAX_RETX, cmr_pkg::CFG_DATA_W'(retx));
    write_reg(cmr_pkg::REG_FIRST_ID, first);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic queue_item(logic [1:0] act, logic [cmr_pkg::ID_W-1:0] id,
                            logic [cmr_pkg::JIT_W-1:0] jit, bit cur);
    stim_t s;
    s.it.action = act;
    s.it.ack_id = id;
    s.it.jitter = jit;
    s.ack_cur   = cur;
    stim_q.push_back(s);
  endtask

  // mostly ticks so the timer reaches expiry, with acks, restarts and noise
  task automatic queue_traffic(int n, int miss_pct);
    int r;
    logic [cmr_pkg::ID_W-1:0]  id;
    logic [cmr_pkg::JIT_W-1:0] jit;
    for (int i = 0; i < n; i++) begin
      r   = $urandom_range(99);
      id  = 16'($urandom_range(16'hFFFF));
      jit = 8'($urandom_range(8'hFF));
      if (r < 3)                  queue_item(cmr_pkg::ACT_START, id, jit, 1'b0);
      else if (r < 8)             queue_item(cmr_pkg::ACT_OTHER, id, jit, 1'b0);
      else if (r < 8 + miss_pct)  queue_item(cmr_pkg::ACT_ACK, id, jit, 1'b0);
      else if (r < 20 + miss_pct) queue_item(cmr_pkg::ACT_ACK, id, jit, 1'b1);
      else                        queue_item(cmr_pkg::ACT_TICK, id, jit, 1'b0);
    end
  endtask

  task automatic wait_idle();
    while (stim_q.size() != 0 || result_q.size() != 0 || in_valid) @(posedge clk);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    snd_idle_pct = 33;
    rcv_idle_pct = 87;
    // idle block ignores ticks and acks, other messages always flag an error
    queue_item(cmr_pkg::ACT_TICK, 16'h0000, 8'h00, 1'b0);
    queue_item(cmr_pkg::ACT_ACK, 16'hFFFF, 8'hFF, 1'b0);
    queue_item(cmr_pkg::ACT_OTHER, 16'hFFFF, 8'hFF, 1'b0);
    queue_item(cmr_pkg::ACT_START, 16'h0000, 8'h00, 1'b0);
    queue_item(cmr_pkg::ACT_TICK, 16'h0000, 8'hFF, 1'b0);
    queue_item(cmr_pkg::ACT_ACK, 16'hFFFF, 8'h00, 1'b0);
    queue_item(cmr_pkg::ACT_ACK, 16'h0000, 8'hFF, 1'b1);
    queue_item(cmr_pkg::ACT_OTHER, 16'h0000, 8'h00, 1'b0);
    // restart while running
    queue_item(cmr_pkg::ACT_START, 16'hFFFF, 8'hFF, 1'b0);
    queue_item(cmr_pkg::ACT_ACK, 16'h0000, 8'h00, 1'b1);
    wait_idle();

    // zero timeout expires on the next tick, id wraps past all ones
    configure(16'd0, 4'd0, 16'hFFFF);
    queue_item(cmr_pkg::ACT_START, 16'h0000, 8'h80, 1'b0);
    queue_item(cmr_pkg::ACT_TICK, 16'h0000, 8'h01, 1'b0);
    queue_item(cmr_pkg::ACT_TICK, 16'h0000, 8'hFE, 1'b0);
    queue_item(cmr_pkg::ACT_ACK, 16'h0000, 8'h00, 1'b0);
    queue_item(cmr_pkg::ACT_ACK, 16'h0000, 8'h7F, 1'b1);
    queue_item(cmr_pkg::ACT_TICK, 16'hAAAA, 8'h55, 1'b0);
    wait_idle();

    configure(16'd1, 4'd15, 16'h0000);
    queue_item(cmr_pkg::ACT_START, 16'h5555, 8'hFF, 1'b0);
    for (int i = 0; i < 4; i++) queue_item(cmr_pkg::ACT_TICK, 16'h0000, 8'h00, 1'b0);
    queue_item(cmr_pkg::ACT_ACK, 16'h0000, 8'hFF, 1'b1);
    wait_idle();

    configure(16'd3, 4'd2, 16'd100);
    queue_traffic(400, 7);
    wait_idle();

    configure(16'd0, 4'd0, 16'hFFFF);
    queue_traffic(300, 7);
    wait_idle();

    snd_idle_pct = 87;
    rcv_idle_pct = 33;
    configure(16'd1, 4'd15, 16'hFFF0);
    queue_traffic(400, 7);
    wait_idle();

    // mismatching acks drive the doubled timeout into saturation
    configure(16'hFFFF, 4'd4, 16'($urandom_range(16'hFFFF)));
    queue_traffic(150, 40);
    wait_idle();

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    configure(16'd5, 4'd7, 16'($urandom_range(16'hFFFF)));
    hold_req = 1'b1;
    queue_traffic(600, 7);
    wait_idle();

    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #1600000;
    $display("Some tests failed");
    $finish;
  end

endmodule
